### rtl/ppne_pkg.sv
// Shared constants, types and helper functions for the point-to-plane normal-equation block.
package ppne_pkg;

    localparam int COORD_BITS  = 32;
    localparam int FRAC_BITS   = 16;
    localparam int NUM_OPS     = 7;
    localparam int OP_BITS     = 3;
    localparam int NUM_SUMS    = 27;
    localparam int ACC_BITS    = 64;
    localparam int IDX_BITS    = 5;
    localparam int PROD_BITS   = 2 * COORD_BITS;
    localparam int RES_BITS    = 2 * COORD_BITS + 1;
    localparam int WIDE_BITS   = 2 * COORD_BITS + 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = QPTR_BITS + 1;

    localparam logic [IDX_BITS-1:0] LAST_ENTRY = IDX_BITS'(NUM_SUMS - 1);

    // Operand slots of a row: 0..2 normal, 3..5 cross product, 6 residual.
    // Entry k of the sums is op[ENTRY_A[k]] * op[ENTRY_B[k]].
    localparam logic [OP_BITS-1:0] ENTRY_A [NUM_SUMS] = '{
        3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
        3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
        3'd2, 3'd2, 3'd2, 3'd2,
        3'd3, 3'd3, 3'd3,
        3'd4, 3'd4,
        3'd5,
        3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6
    };
    localparam logic [OP_BITS-1:0] ENTRY_B [NUM_SUMS] = '{
        3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5,
        3'd1, 3'd2, 3'd3, 3'd4, 3'd5,
        3'd2, 3'd3, 3'd4, 3'd5,
        3'd3, 3'd4, 3'd5,
        3'd4, 3'd5,
        3'd5,
        3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5
    };

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        logic [NUM_OPS-1:0][COORD_BITS-1:0] op;
        logic                               last;
    } row_t;

    typedef struct packed {
        logic [QCNT_BITS-1:0] count;
        logic                 not_empty;
    } queue_stat_t;

    typedef enum logic {
        ST_ACCUM,
        ST_EMIT
    } back_state_t;

    // Clamp a wide signed value to the signed coordinate range.
    function automatic coord_t sat_coord(input logic signed [WIDE_BITS-1:0] x);
        logic [WIDE_BITS-COORD_BITS:0] upper;
        upper = x[WIDE_BITS-1:COORD_BITS-1];
        if (upper == '0 || upper == '1)
            return x[COORD_BITS-1:0];
        else if (x[WIDE_BITS-1])
            return {1'b1, {(COORD_BITS-1){1'b0}}};
        else
            return {1'b0, {(COORD_BITS-1){1'b1}}};
    endfunction

endpackage

### rtl/ppne_front.sv
// Front end: takes correspondence requests and forms the Jacobian row and residual.
module ppne_front
    import ppne_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [COORD_BITS-1:0] src_x,
    input  logic signed [COORD_BITS-1:0] src_y,
    input  logic signed [COORD_BITS-1:0] src_z,
    input  logic signed [COORD_BITS-1:0] dst_x,
    input  logic signed [COORD_BITS-1:0] dst_y,
    input  logic signed [COORD_BITS-1:0] dst_z,
    input  logic signed [COORD_BITS-1:0] nrm_x,
    input  logic signed [COORD_BITS-1:0] nrm_y,
    input  logic signed [COORD_BITS-1:0] nrm_z,
    input  logic                    is_last,
    input  queue_stat_t             q_stat,
    output logic                    push_valid,
    output row_t                    push_row
);

    logic                        s1_valid_reg;
    logic                        s2_valid_reg;
    logic signed [PROD_BITS-1:0] cross_reg [6];
    logic signed [PROD_BITS-1:0] cross_next [6];
    logic signed [RES_BITS-1:0]  res_reg [3];
    logic signed [RES_BITS-1:0]  res_next [3];
    coord_t                      nrm_reg [3];
    logic                        last_reg;
    row_t                        row_reg;
    row_t                        row_next;
    logic [QCNT_BITS:0]          inflight;
    logic                        take;

    // Every item in either stage already owns a queue slot.
    assign inflight = (QCNT_BITS+1)'(q_stat.count) + (QCNT_BITS+1)'(s1_valid_reg)
                    + (QCNT_BITS+1)'(s2_valid_reg);
    assign in_ready = (inflight < (QCNT_BITS+1)'(QUEUE_DEPTH));
    assign take     = in_valid && in_ready;

    always_comb
    begin
        cross_next[0] = src_y * nrm_z;
        cross_next[1] = src_z * nrm_y;
        cross_next[2] = src_z * nrm_x;
        cross_next[3] = src_x * nrm_z;
        cross_next[4] = src_x * nrm_y;
        cross_next[5] = src_y * nrm_x;
        res_next[0]   = nrm_x * ($signed({src_x[COORD_BITS-1], src_x})
                               - $signed({dst_x[COORD_BITS-1], dst_x}));
        res_next[1]   = nrm_y * ($signed({src_y[COORD_BITS-1], src_y})
                               - $signed({dst_y[COORD_BITS-1], dst_y}));
        res_next[2]   = nrm_z * ($signed({src_z[COORD_BITS-1], src_z})
                               - $signed({dst_z[COORD_BITS-1], dst_z}));
    end

    always_comb
    begin
        logic signed [WIDE_BITS-1:0] diff;
        logic signed [WIDE_BITS-1:0] rsum;
        row_next.op[0] = nrm_reg[0];
        row_next.op[1] = nrm_reg[1];
        row_next.op[2] = nrm_reg[2];
        for (int c = 0; c < 3; c++)
        begin
            diff = WIDE_BITS'(cross_reg[2*c]) - WIDE_BITS'(cross_reg[2*c+1]);
            row_next.op[3+c] = sat_coord(diff >>> FRAC_BITS);
        end
        rsum = WIDE_BITS'(res_reg[0]) + WIDE_BITS'(res_reg[1]) + WIDE_BITS'(res_reg[2]);
        row_next.op[6] = sat_coord(rsum >>> FRAC_BITS);
        row_next.last  = last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= take;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 6; i++)
            cross_reg[i] <= cross_next[i];
        for (int i = 0; i < 3; i++)
            res_reg[i] <= res_next[i];
        nrm_reg[0] <= nrm_x;
        nrm_reg[1] <= nrm_y;
        nrm_reg[2] <= nrm_z;
        last_reg   <= is_last;
        row_reg    <= row_next;
    end

    assign push_valid = s2_valid_reg;
    assign push_row   = row_reg;

endmodule

### rtl/ppne_queue.sv
// Short row queue between the front end and the accumulating back end.
module ppne_queue
    import ppne_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  row_t        push_row,
    input  logic        pop,
    output row_t        head_row,
    output queue_stat_t q_stat
);

    row_t                 mem_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QCNT_BITS-1:0] count_reg;
    logic [QCNT_BITS-1:0] count_next;

    always_comb
    begin
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_row;
    end

    assign head_row         = mem_reg[rd_ptr_reg];
    assign q_stat.count     = count_reg;
    assign q_stat.not_empty = (count_reg != '0);

endmodule

### rtl/ppne_back.sv
// Back end: forms the 27 products per row, accumulates them and emits the sums.
module ppne_back
    import ppne_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  row_t                       head_row,
    input  queue_stat_t                q_stat,
    output logic                       pop,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [IDX_BITS-1:0]        entry_index,
    output logic signed [ACC_BITS-1:0] entry_value,
    output logic                       final_entry
);

    back_state_t                 state_reg;
    back_state_t                 state_next;
    logic                        prod_valid_reg;
    logic                        prod_last_reg;
    logic signed [PROD_BITS-1:0] prod_reg [NUM_SUMS];
    logic signed [PROD_BITS-1:0] prod_next [NUM_SUMS];
    logic signed [ACC_BITS-1:0]  accum_reg [NUM_SUMS];
    logic signed [ACC_BITS-1:0]  accum_next [NUM_SUMS];
    logic [IDX_BITS-1:0]         idx_reg;
    logic [IDX_BITS-1:0]         idx_next;
    logic                        out_valid_reg;
    logic [IDX_BITS-1:0]         out_idx_reg;
    logic signed [ACC_BITS-1:0]  out_value_reg;
    logic                        out_final_reg;
    logic                        advance;
    logic                        accumulate;
    logic                        out_load;
    logic                        clear;
    coord_t                      op_val [NUM_OPS];

    always_comb
    begin
        for (int k = 0; k < NUM_OPS; k++)
            op_val[k] = head_row.op[k];
        for (int k = 0; k < NUM_SUMS; k++)
            prod_next[k] = op_val[ENTRY_A[k]] * op_val[ENTRY_B[k]];
    end

    // Sequencer: accumulate rows until a last row lands, then drain the sums.
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        advance    = 1'b0;
        out_load   = 1'b0;
        clear      = 1'b0;
        unique case (state_reg)
            ST_ACCUM:
            begin
                advance = 1'b1;
                if (prod_valid_reg && prod_last_reg)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load = 1'b1;
                    if (idx_reg == LAST_ENTRY)
                    begin
                        idx_next   = '0;
                        clear      = 1'b1;
                        state_next = ST_ACCUM;
                    end
                    else
                        idx_next = idx_reg + 1'b1;
                end
            end
            default:
                state_next = ST_ACCUM;
        endcase
    end

    assign pop        = advance && q_stat.not_empty;
    assign accumulate = advance && prod_valid_reg;

    always_comb
    begin
        logic signed [ACC_BITS:0] sum;
        for (int k = 0; k < NUM_SUMS; k++)
        begin
            sum = (ACC_BITS+1)'(accum_reg[k]) + (ACC_BITS+1)'(prod_reg[k]);
            if (clear)
                accum_next[k] = '0;
            else if (!accumulate)
                accum_next[k] = accum_reg[k];
            else if (sum[ACC_BITS] != sum[ACC_BITS-1])
                accum_next[k] = sum[ACC_BITS] ? {1'b1, {(ACC_BITS-1){1'b0}}}
                                              : {1'b0, {(ACC_BITS-1){1'b1}}};
            else
                accum_next[k] = sum[ACC_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_ACCUM;
            idx_reg        <= '0;
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int k = 0; k < NUM_SUMS; k++)
                accum_reg[k] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (advance)
                prod_valid_reg <= q_stat.not_empty;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            for (int k = 0; k < NUM_SUMS; k++)
                accum_reg[k] <= accum_next[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            prod_last_reg <= head_row.last;
            for (int k = 0; k < NUM_SUMS; k++)
                prod_reg[k] <= prod_next[k];
        end
        if (out_load)
        begin
            out_idx_reg   <= idx_reg;
            out_value_reg <= accum_reg[idx_reg];
            out_final_reg <= (idx_reg == LAST_ENTRY);
        end
    end

    assign out_valid   = out_valid_reg;
    assign entry_index = out_idx_reg;
    assign entry_value = out_value_reg;
    assign final_entry = out_final_reg;

endmodule

### rtl/point_to_plane_normal_equations_top.sv
// Top level of the point-to-plane normal-equation accumulator.
//
// Input channel (in_valid/in_ready): one request is one correspondence, a
// source point, a target point and the target normal in signed Q16.16, plus
// is_last marking the final correspondence of a set. Output channel
// (out_valid/out_ready): one request is one accumulated sum in signed Q32.32
// with its entry_index; final_entry flags entry 26.
// The front end takes one request per cycle, sustained while queue credit
// lasts, spends two pipeline stages forming the Jacobian row and residual,
// and parks the row in a four-entry queue. While accumulating, the back end
// pops one row per cycle if the queue holds one, registers its 27 products
// and adds them into 27 saturating accumulators. A last request reaches the
// output register via the front stages, the queue, the product register
// and the accumulators; the 27 sums then leave one per cycle while the
// receiver takes them, and rows pile up in the queue meanwhile, so input
// stalls once the queue credit is gone. When out_ready is low the output
// register holds its sum and the drain pauses. After the final sum is loaded
// the accumulators clear and the next set starts accumulating at once.
// Reset empties the pipeline and queue and zeroes all accumulators.
module point_to_plane_normal_equations_top
    import ppne_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [COORD_BITS-1:0] src_x,
    input  logic signed [COORD_BITS-1:0] src_y,
    input  logic signed [COORD_BITS-1:0] src_z,
    input  logic signed [COORD_BITS-1:0] dst_x,
    input  logic signed [COORD_BITS-1:0] dst_y,
    input  logic signed [COORD_BITS-1:0] dst_z,
    input  logic signed [COORD_BITS-1:0] nrm_x,
    input  logic signed [COORD_BITS-1:0] nrm_y,
    input  logic signed [COORD_BITS-1:0] nrm_z,
    input  logic                         is_last,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [IDX_BITS-1:0]          entry_index,
    output logic signed [ACC_BITS-1:0]   entry_value,
    output logic                         final_entry
);

    logic        push_valid;
    row_t        push_row;
    row_t        head_row;
    logic        pop;
    queue_stat_t q_stat;

    // Front end: row and residual formation, with queue-credit flow control.
    ppne_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .src_x      (src_x),
        .src_y      (src_y),
        .src_z      (src_z),
        .dst_x      (dst_x),
        .dst_y      (dst_y),
        .dst_z      (dst_z),
        .nrm_x      (nrm_x),
        .nrm_y      (nrm_y),
        .nrm_z      (nrm_z),
        .is_last    (is_last),
        .q_stat     (q_stat),
        .push_valid (push_valid),
        .push_row   (push_row)
    );

    // The queue lets the back end drain sums while rows keep arriving.
    ppne_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push_valid),
        .push_row (push_row),
        .pop      (pop),
        .head_row (head_row),
        .q_stat   (q_stat)
    );

    // Back end: products, saturating accumulation and the drain sequencer.
    ppne_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_row    (head_row),
        .q_stat      (q_stat),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .entry_index (entry_index),
        .entry_value (entry_value),
        .final_entry (final_entry)
    );

    // The credit check must keep the queue from ever overfilling.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.count <= QCNT_BITS'(QUEUE_DEPTH))
        else $error("row queue overfilled");

    // Only the last sum of a drain carries the final flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && final_entry |-> entry_index == LAST_ENTRY)
        else $error("final flag on a sum other than the last");

    // Within a drain the sums follow each other in index order without gaps.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !final_entry |=>
            out_valid && (entry_index == IDX_BITS'($past(entry_index) + 1'b1)))
        else $error("sum drain skipped or repeated an entry");

endmodule

### dv/point_to_plane_normal_equations_top_test.sv
// Self-checking testbench for the point-to-plane normal-equation accumulator.
`timescale 1ns / 100ps

module point_to_plane_normal_equations_top_test;
    import ppne_pkg::*;

    // One correspondence as the sender drives it.
    typedef struct {
        coord_t sx, sy, sz;
        coord_t dx, dy, dz;
        coord_t nx, ny, nz;
        logic   last;
    } corr_t;

    // One accumulated sum as the block should emit it.
    typedef struct {
        logic [IDX_BITS-1:0]        idx;
        logic signed [ACC_BITS-1:0] value;
        logic                       fin;
    } sum_entry_t;

    // Value styles for the random coordinates.
    localparam int unsigned STYLE_FINE   = 0;
    localparam int unsigned STYLE_COARSE = 1;
    localparam int unsigned STYLE_RAW    = 2;
    localparam int unsigned STYLE_EDGE   = 3;

    localparam coord_t CMAX = 32'sh7fff_ffff;
    localparam coord_t CMIN = 32'sh8000_0000;
    localparam coord_t ONE  = 32'sh0001_0000;

    localparam logic signed [79:0] WIDE_HI = 80'sh7fff_ffff;
    localparam logic signed [79:0] WIDE_LO = -WIDE_HI - 80'sd1;
    localparam logic signed [65:0] ACC_HI  = 66'sh0_7fff_ffff_ffff_ffff;
    localparam logic signed [65:0] ACC_LO  = -ACC_HI - 66'sd1;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic   in_valid = 1'b0;
    logic   in_ready;
    coord_t src_x = '0, src_y = '0, src_z = '0;
    coord_t dst_x = '0, dst_y = '0, dst_z = '0;
    coord_t nrm_x = '0, nrm_y = '0, nrm_z = '0;
    logic   is_last = 1'b0;

    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic [IDX_BITS-1:0]        entry_index;
    logic signed [ACC_BITS-1:0] entry_value;
    logic                       final_entry;

    // Idle rates, in percent of cycles, for the sender and the receiver.
    int unsigned send_gap_pct   = 0;
    int unsigned recv_stall_pct = 0;

    int unsigned error_count = 0;

    // Running normal-equation sums of the current set, as the block should hold them.
    longint     normal_sums [NUM_SUMS];
    // Sums that have been predicted but not yet seen on the output, oldest first.
    sum_entry_t sums_due [$];

    point_to_plane_normal_equations_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .src_x       (src_x),
        .src_y       (src_y),
        .src_z       (src_z),
        .dst_x       (dst_x),
        .dst_y       (dst_y),
        .dst_z       (dst_z),
        .nrm_x       (nrm_x),
        .nrm_y       (nrm_y),
        .nrm_z       (nrm_z),
        .is_last     (is_last),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .entry_index (entry_index),
        .entry_value (entry_value),
        .final_entry (final_entry)
    );

    always #10 clk = ~clk;

    // Clamp an exact wide value to the signed 32-bit coordinate range.
    function automatic coord_t clamp_coord(input logic signed [79:0] x);
        if (x > WIDE_HI)
            return CMAX;
        if (x < WIDE_LO)
            return CMIN;
        return x[31:0];
    endfunction

    // Saturating 64-bit add, as each accumulator update does.
    function automatic longint sat_add64(input longint a, input longint b);
        logic signed [65:0] t;
        t = a + b;
        if (t > ACC_HI)
            return ACC_HI[63:0];
        if (t < ACC_LO)
            return ACC_LO[63:0];
        return t[63:0];
    endfunction

    // Fold one accepted correspondence into the running sums. On the last one
    // of a set, queue up all 27 sums in index order and start the next set at zero.
    function automatic void accumulate_correspondence(input corr_t c);
        coord_t             row [6];
        coord_t             resid;
        logic signed [79:0] wide;
        logic signed [63:0] prod;
        int                 k;
        sum_entry_t         e;
        row[0] = c.nx;
        row[1] = c.ny;
        row[2] = c.nz;
        // Arithmetic right shift of the exact value floors toward minus infinity.
        wide   = c.sy * c.nz - c.sz * c.ny;
        row[3] = clamp_coord(wide >>> FRAC_BITS);
        wide   = c.sz * c.nx - c.sx * c.nz;
        row[4] = clamp_coord(wide >>> FRAC_BITS);
        wide   = c.sx * c.ny - c.sy * c.nx;
        row[5] = clamp_coord(wide >>> FRAC_BITS);
        wide   = c.nx * (c.sx - c.dx) + c.ny * (c.sy - c.dy) + c.nz * (c.sz - c.dz);
        resid  = clamp_coord(wide >>> FRAC_BITS);
        k = 0;
        for (int i = 0; i < 6; i++)
        begin
            for (int j = i; j < 6; j++)
            begin
                prod = row[i] * row[j];
                normal_sums[k] = sat_add64(normal_sums[k], prod);
                k++;
            end
        end
        for (int i = 0; i < 6; i++)
        begin
            prod = resid * row[i];
            normal_sums[21 + i] = sat_add64(normal_sums[21 + i], prod);
        end
        if (c.last)
        begin
            for (int m = 0; m < NUM_SUMS; m++)
            begin
                e.idx   = IDX_BITS'(m);
                e.value = normal_sums[m];
                e.fin   = (m == NUM_SUMS - 1);
                sums_due.insert(sums_due.size(), e);
                normal_sums[m] = 0;
            end
        end
    endfunction

    function automatic corr_t make_corr(input coord_t sx, sy, sz, dx, dy, dz, nx, ny, nz,
                                        input logic last);
        corr_t c;
        c.sx = sx; c.sy = sy; c.sz = sz;
        c.dx = dx; c.dy = dy; c.dz = dz;
        c.nx = nx; c.ny = ny; c.nz = nz;
        c.last = last;
        return c;
    endfunction

    function automatic coord_t draw_coord(input int unsigned style);
        case (style)
            STYLE_FINE:   return coord_t'(int'($urandom_range(1 << 20)) - (1 << 19));
            STYLE_COARSE: return coord_t'(int'($urandom_range(1 << 28)) - (1 << 27));
            STYLE_RAW:    return coord_t'($urandom);
            default:
            begin
                case ($urandom_range(6))
                    0:       return CMAX;
                    1:       return CMIN;
                    2:       return '0;
                    3:       return -32'sd1;
                    4:       return 32'sd1;
                    5:       return coord_t'(32'd1 << $urandom_range(31));
                    default: return ~coord_t'(32'd1 << $urandom_range(31));
                endcase
            end
        endcase
    endfunction

    // Send one request. The sender may idle first; valid stays high after the
    // handshake so back-to-back requests never drop it in between.
    task automatic send_request(input corr_t c);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        src_x   <= c.sx;
        src_y   <= c.sy;
        src_z   <= c.sz;
        dst_x   <= c.dx;
        dst_y   <= c.dy;
        dst_z   <= c.dz;
        nrm_x   <= c.nx;
        nrm_y   <= c.ny;
        nrm_z   <= c.nz;
        is_last <= c.last;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        accumulate_correspondence(c);
    endtask

    // Hold the sender off until every predicted sum has come out.
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sums_due.size() != 0);
    endtask

    // Receiver: check each sum taken at an edge against the oldest prediction,
    // then decide whether to stall for the next cycle.
    always @(posedge clk)
    begin
        sum_entry_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (sums_due.size() == 0)
            begin
                $display("%0t: unexpected sum: index %0d value %0d final %0b",
                         $time, entry_index, entry_value, final_entry);
                error_count++;
            end
            else
            begin
                e = sums_due.pop_front();
                if (entry_index !== e.idx)
                begin
                    $display("%0t: entry_index expected %0d, actual %0d",
                             $time, e.idx, entry_index);
                    error_count++;
                end
                if (entry_value !== e.value)
                begin
                    $display("%0t: entry_value of sum %0d expected %0d, actual %0d",
                             $time, e.idx, e.value, entry_value);
                    error_count++;
                end
                if (final_entry !== e.fin)
                begin
                    $display("%0t: final_entry of sum %0d expected %0b, actual %0b",
                             $time, e.idx, e.fin, final_entry);
                    error_count++;
                end
            end
        end
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // An all-zero single-request set must give 27 zero sums.
    task automatic test_zero_set();
        send_request(make_corr('0, '0, '0, '0, '0, '0, '0, '0, '0, 1'b1));
    endtask

    // Full-scale coordinates: the residual and some of the cross terms clamp to
    // the coordinate range.
    task automatic test_extreme_coordinates();
        send_request(make_corr(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 1'b0));
        send_request(make_corr(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, 1'b0));
        send_request(make_corr(CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMIN, CMAX, CMIN, 1'b1));
        send_request(make_corr(CMIN, CMAX, '0, CMAX, '0, CMIN, CMAX, CMIN, CMAX, 1'b1));
    endtask

    // Small odd values of mixed sign, so the floor of negative cross terms and
    // residuals differs from truncation.
    task automatic test_floor_rounding();
        send_request(make_corr(-32'sd1, 32'sd3, -32'sd5, 32'sd2, -32'sd7, 32'sd1,
                               32'sd1, -32'sd1, 32'sd3, 1'b0));
        send_request(make_corr(ONE + 32'sd1, -ONE, 32'sd1, -ONE, ONE, -32'sd1,
                               32'sd1, ONE - 32'sd1, -32'sd1, 1'b0));
        send_request(make_corr(-32'sd1, '0, '0, '0, '0, '0, '0, 32'sd1, '0, 1'b1));
    endtask

    // Repeated full-scale normals drive the accumulators past both ends of
    // the 64-bit range.
    task automatic test_accumulator_saturation();
        repeat (3)
            send_request(make_corr('0, '0, '0, '0, '0, '0, CMIN, CMAX, CMIN, 1'b0));
        send_request(make_corr(ONE, -ONE, ONE, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, 1'b1));
    endtask

    // Back-to-back one-request sets check that the sums clear after each emission.
    task automatic test_back_to_back_sets();
        send_request(make_corr(ONE, ONE, ONE, '0, '0, '0, ONE, '0, '0, 1'b1));
        send_request(make_corr(-ONE, ONE, -ONE, ONE, -ONE, ONE, '0, ONE, '0, 1'b1));
        send_request(make_corr(ONE, 2 * ONE, 3 * ONE, -ONE, '0, ONE, '0, '0, -ONE, 1'b1));
    endtask

    // Random sets of correspondences under the given idle rates. Most sets use
    // realistic small values; a few use raw bit patterns or edge values.
    task automatic test_random_stream(input int unsigned count, input int unsigned gap_pct,
                                      input int unsigned stall_pct);
        int unsigned sent;
        int unsigned set_len;
        int unsigned pick;
        int unsigned style;
        corr_t       c;
        send_gap_pct   = gap_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < count)
        begin
            set_len = ($urandom_range(99) < 85) ? $urandom_range(1, 8) : $urandom_range(9, 24);
            pick = $urandom_range(99);
            for (int unsigned n = 0; n < set_len; n++)
            begin
                style = (pick < 55) ? STYLE_FINE :
                        (pick < 75) ? STYLE_COARSE :
                        (pick < 88) ? STYLE_RAW : $urandom_range(STYLE_EDGE);
                c = make_corr(draw_coord(style), draw_coord(style), draw_coord(style),
                              draw_coord(style), draw_coord(style), draw_coord(style),
                              draw_coord(style), draw_coord(style), draw_coord(style),
                              n == set_len - 1);
                send_request(c);
                sent++;
            end
        end
    endtask

    initial
    begin
        for (int m = 0; m < NUM_SUMS; m++)
            normal_sums[m] = 0;
        send_gap_pct   = 10;
        recv_stall_pct = 50;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_zero_set();
        test_extreme_coordinates();
        test_floor_rounding();
        test_accumulator_saturation();
        test_back_to_back_sets();
        // Let the block empty completely before the random stream starts.
        wait_for_drain();

        test_random_stream(105, 10, 50);
        wait_for_drain();
        test_random_stream(105, 50, 10);
        wait_for_drain();
        test_random_stream(110, 0, 0);
        wait_for_drain();

        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run of this stimulus.
    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

### filelist.f
rtl/ppne_pkg.sv
rtl/ppne_front.sv
rtl/ppne_queue.sv
rtl/ppne_back.sv
rtl/point_to_plane_normal_equations_top.sv
dv/point_to_plane_normal_equations_top_test.sv
